>>> hdl/lpc_pkg.sv
// ============================================================================
// lpc_pkg: shared types and constants of the LRAT proof chain checker
// Table sizes, field widths, command codes, controller steps and the
// command/status bundles between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

    // Table sizes. CLAUSE_SLOTS and VAR_COUNT are powers of two.
    localparam int CLAUSE_SLOTS = 4096;
    localparam int MAX_LITERALS = 32;
    localparam int MAX_CHAIN    = 64;
    localparam int VAR_COUNT    = 4096;

    // Fixed widths of the item fields.
    localparam int CMD_W = 3;
    localparam int ID_W  = 12;

    localparam int SLOT_W  = $clog2(CLAUSE_SLOTS);
    localparam int VAR_W   = $clog2(VAR_COUNT);
    localparam int LIT_W   = VAR_W + 1;
    localparam int CLEN_W  = $clog2(MAX_LITERALS + 1);
    localparam int HLEN_W  = $clog2(MAX_CHAIN + 1);
    localparam int FILL_W  = (HLEN_W > CLEN_W) ? HLEN_W : CLEN_W;
    localparam int FILL_MAX = (MAX_CHAIN > MAX_LITERALS) ? MAX_CHAIN : MAX_LITERALS;
    localparam int LADDR_W = $clog2(CLAUSE_SLOTS * MAX_LITERALS);
    localparam int HADDR_W = $clog2(CLAUSE_SLOTS * MAX_CHAIN);
    localparam int GEN_W   = 8;
    localparam int ASG_W   = GEN_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LIT       = 3'd0,
        CMD_CHAIN     = 3'd1,
        CMD_FORGET    = 3'd2,
        CMD_VALIDATE  = 3'd3,
        CMD_CHECK_ALL = 3'd4,
        CMD_FINALIZE  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_ONE,
        MODE_ALL,
        MODE_FINAL
    } mode_t;

    typedef enum logic [4:0] {
        S_INIT_CLR,
        S_IDLE,
        S_Q_PRES,
        S_SCAN_RD,
        S_SCAN_EV,
        S_NEXT,
        S_V_START,
        S_TAG_CLR,
        S_V_LEN,
        S_V_LEN2,
        S_D_RD,
        S_D_WR,
        S_C_RD,
        S_A_RD,
        S_A_EV,
        S_L_RD,
        S_L_AS,
        S_L_EV,
        S_A_END,
        S_V_OK,
        S_V_FAIL,
        S_FINISH
    } step_t;

    typedef struct packed {
        step_t op;
        logic  accept;
    } dp_cmd_t;

    typedef struct packed {
        logic  sweep_last;
        logic  pres_ok;
        logic  scan_verify;
        logic  scan_abort;
        logic  gen_wrap;
        logic  dlen_zero;
        logic  d_last;
        logic  ch_end;
        logic  ant_absent;
        logic  lit_end;
        logic  lit_sat;
        logic  open_zero;
        logic  open_multi;
        logic  slot_last;
        logic  out_free;
        mode_t mode;
    } dp_status_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] x);
        return SLOT_W'(32'(x) % CLAUSE_SLOTS);
    endfunction

    function automatic logic [VAR_W-1:0] var_of(input logic [ID_W-1:0] x);
        return VAR_W'(32'(x) % VAR_COUNT);
    endfunction

    function automatic logic [LADDR_W-1:0] lit_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [CLEN_W-1:0] i);
        return LADDR_W'(s) * LADDR_W'(MAX_LITERALS) + LADDR_W'(i);
    endfunction

    function automatic logic [HADDR_W-1:0] chain_addr(input logic [SLOT_W-1:0] s,
                                                      input logic [HLEN_W-1:0] i);
        return HADDR_W'(s) * HADDR_W'(MAX_CHAIN) + HADDR_W'(i);
    endfunction

endpackage

`default_nettype wire

>>> hdl/lpc_ram.sv
// ============================================================================
// lpc_ram: generic memory
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/lpc_ctrl.sv
// ============================================================================
// lpc_ctrl: sequencer of the proof chain checker
// Steps through clearing, record handling, table scans and the unit
// propagation walk, driven by datapath status.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lpc_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [lpc_pkg::CMD_W-1:0]    command,
    input  wire logic                         id_valid,
    input  wire lpc_pkg::dp_status_t          status,
    output lpc_pkg::dp_cmd_t                  cmd
);

    lpc_pkg::step_t state_reg;
    lpc_pkg::step_t state_next;
    logic           accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpc_pkg::S_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpc_pkg::S_INIT_CLR:
            begin
                if (status.sweep_last)
                    state_next = lpc_pkg::S_IDLE;
            end
            lpc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (command == lpc_pkg::CMD_VALIDATE)
                        state_next = id_valid ? lpc_pkg::S_Q_PRES : lpc_pkg::S_FINISH;
                    else if (command == lpc_pkg::CMD_CHECK_ALL ||
                             command == lpc_pkg::CMD_FINALIZE)
                        state_next = lpc_pkg::S_SCAN_RD;
                end
            end
            lpc_pkg::S_Q_PRES:
                state_next = status.pres_ok ? lpc_pkg::S_V_START : lpc_pkg::S_FINISH;
            lpc_pkg::S_SCAN_RD:
                state_next = lpc_pkg::S_SCAN_EV;
            lpc_pkg::S_SCAN_EV:
            begin
                if (status.scan_abort)
                    state_next = lpc_pkg::S_FINISH;
                else if (status.scan_verify)
                    state_next = lpc_pkg::S_V_START;
                else
                    state_next = lpc_pkg::S_NEXT;
            end
            lpc_pkg::S_NEXT:
                state_next = status.slot_last ? lpc_pkg::S_FINISH : lpc_pkg::S_SCAN_RD;
            lpc_pkg::S_V_START:
                state_next = status.gen_wrap ? lpc_pkg::S_TAG_CLR : lpc_pkg::S_V_LEN;
            lpc_pkg::S_TAG_CLR:
            begin
                if (status.sweep_last)
                    state_next = lpc_pkg::S_V_LEN;
            end
            lpc_pkg::S_V_LEN:
                state_next = lpc_pkg::S_V_LEN2;
            lpc_pkg::S_V_LEN2:
                state_next = status.dlen_zero ? lpc_pkg::S_C_RD : lpc_pkg::S_D_RD;
            lpc_pkg::S_D_RD:
                state_next = lpc_pkg::S_D_WR;
            lpc_pkg::S_D_WR:
                state_next = status.d_last ? lpc_pkg::S_C_RD : lpc_pkg::S_D_RD;
            lpc_pkg::S_C_RD:
                state_next = status.ch_end ? lpc_pkg::S_V_FAIL : lpc_pkg::S_A_RD;
            lpc_pkg::S_A_RD:
                state_next = lpc_pkg::S_A_EV;
            lpc_pkg::S_A_EV:
                state_next = status.ant_absent ? lpc_pkg::S_V_FAIL : lpc_pkg::S_L_RD;
            lpc_pkg::S_L_RD:
                state_next = status.lit_end ? lpc_pkg::S_A_END : lpc_pkg::S_L_AS;
            lpc_pkg::S_L_AS:
                state_next = lpc_pkg::S_L_EV;
            lpc_pkg::S_L_EV:
                state_next = status.lit_sat ? lpc_pkg::S_V_FAIL : lpc_pkg::S_L_RD;
            lpc_pkg::S_A_END:
            begin
                if (status.open_zero)
                    state_next = lpc_pkg::S_V_OK;
                else if (status.open_multi)
                    state_next = lpc_pkg::S_V_FAIL;
                else
                    state_next = lpc_pkg::S_C_RD;
            end
            lpc_pkg::S_V_OK:
                state_next = (status.mode == lpc_pkg::MODE_ALL) ?
                             lpc_pkg::S_NEXT : lpc_pkg::S_FINISH;
            lpc_pkg::S_V_FAIL:
                state_next = (status.mode == lpc_pkg::MODE_FINAL) ?
                             lpc_pkg::S_NEXT : lpc_pkg::S_FINISH;
            lpc_pkg::S_FINISH:
            begin
                if (status.out_free)
                    state_next = lpc_pkg::S_IDLE;
            end
            default:
                state_next = lpc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == lpc_pkg::S_IDLE);
        cmd.op     = state_reg;
        cmd.accept = in_valid && (state_reg == lpc_pkg::S_IDLE);
    end

endmodule

`default_nettype wire

>>> hdl/lpc_dp.sv
// ============================================================================
// lpc_dp: datapath of the proof chain checker
// Clause and chain tables, the tagged assignment table, record tracking,
// walk counters and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lpc_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lpc_pkg::dp_cmd_t              cmd,
    output lpc_pkg::dp_status_t                status,
    input  wire logic [lpc_pkg::CMD_W-1:0]     command,
    input  wire logic [lpc_pkg::ID_W-1:0]      clause_id,
    input  wire logic                          id_valid,
    input  wire logic                          has_element,
    input  wire logic [lpc_pkg::ID_W-1:0]      literal_var,
    input  wire logic                          literal_negated,
    input  wire logic [lpc_pkg::ID_W-1:0]      antecedent_id,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               verdict,
    output logic                               overflow_seen
);

    // Control registers.
    logic [lpc_pkg::SLOT_W-1:0] sweep_reg, sweep_next;
    logic [lpc_pkg::GEN_W-1:0]  gen_reg, gen_next;
    logic                       rec_open_reg, rec_open_next;
    logic                       rec_drop_reg, rec_drop_next;
    logic [lpc_pkg::FILL_W-1:0] rec_fill_reg, rec_fill_next;
    logic                       ovf_flag_reg, ovf_flag_next;
    logic                       out_valid_reg, out_valid_next;

    // Payload registers.
    logic                       rec_kind_reg, rec_kind_next;
    logic [lpc_pkg::SLOT_W-1:0] rec_slot_reg, rec_slot_next;
    lpc_pkg::mode_t             mode_reg, mode_next;
    logic [lpc_pkg::SLOT_W-1:0] scan_slot_reg, scan_slot_next;
    logic [lpc_pkg::SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [lpc_pkg::CLEN_W-1:0] dlen_reg, dlen_next;
    logic [lpc_pkg::CLEN_W-1:0] dcnt_reg, dcnt_next;
    logic [lpc_pkg::HLEN_W-1:0] chlen_reg, chlen_next;
    logic [lpc_pkg::HLEN_W-1:0] chcnt_reg, chcnt_next;
    logic [lpc_pkg::SLOT_W-1:0] ant_reg, ant_next;
    logic [lpc_pkg::CLEN_W-1:0] alen_reg, alen_next;
    logic [lpc_pkg::CLEN_W-1:0] acnt_reg, acnt_next;
    logic [1:0]                 open_reg, open_next;
    logic [lpc_pkg::LIT_W-1:0]  pend_reg, pend_next;
    logic [lpc_pkg::LIT_W-1:0]  cur_lit_reg, cur_lit_next;
    logic                       verdict_reg, verdict_next;
    logic                       out_verdict_reg, out_verdict_next;
    logic                       out_ovf_reg, out_ovf_next;

    // Memory ports.
    logic                        cpres_we, hpres_we, clen_we, hlen_we;
    logic                        cpres_wd, hpres_wd;
    logic [lpc_pkg::SLOT_W-1:0]  tab_wa, tab_ra;
    logic [lpc_pkg::CLEN_W-1:0]  clen_wd;
    logic [lpc_pkg::HLEN_W-1:0]  hlen_wd;
    logic                        cpres_q, hpres_q;
    logic [lpc_pkg::CLEN_W-1:0]  clen_q;
    logic [lpc_pkg::HLEN_W-1:0]  hlen_q;
    logic                        lits_we;
    logic [lpc_pkg::LADDR_W-1:0] lits_wa, lits_ra;
    logic [lpc_pkg::LIT_W-1:0]   lits_wd, lits_q;
    logic                        chids_we;
    logic [lpc_pkg::HADDR_W-1:0] chids_wa, chids_ra;
    logic [lpc_pkg::SLOT_W-1:0]  chids_wd, chids_q;
    logic                        asg_we;
    logic [lpc_pkg::VAR_W-1:0]   asg_wa, asg_ra;
    logic [lpc_pkg::ASG_W-1:0]   asg_wd, asg_q;

    // Record item decode.
    logic [lpc_pkg::SLOT_W-1:0] in_slot;
    logic                       rec_item, rec_kind, rec_new, rec_drop_eff;
    logic [lpc_pkg::FILL_W-1:0] rec_fill_eff, rec_bound, rec_fill_new;
    logic                       rec_elem, rec_ovf, rec_store, rec_drop_new, rec_commit;
    logic                       out_free;
    logic [lpc_pkg::GEN_W-1:0]  asg_tag;

    assign in_slot  = lpc_pkg::slot_of(clause_id);
    assign rec_item = cmd.accept && id_valid &&
                      (command == lpc_pkg::CMD_LIT || command == lpc_pkg::CMD_CHAIN);
    assign rec_kind = (command == lpc_pkg::CMD_CHAIN);
    assign rec_new  = !rec_open_reg || (rec_kind_reg != rec_kind) ||
                      (rec_slot_reg != in_slot);
    assign rec_fill_eff = rec_new ? '0 : rec_fill_reg;
    assign rec_drop_eff = rec_new ? 1'b0 : rec_drop_reg;
    assign rec_bound    = rec_kind ? lpc_pkg::FILL_W'(lpc_pkg::MAX_CHAIN)
                                   : lpc_pkg::FILL_W'(lpc_pkg::MAX_LITERALS);
    assign rec_elem     = has_element && !rec_drop_eff;
    assign rec_ovf      = rec_elem && (rec_fill_eff >= rec_bound);
    assign rec_store    = rec_elem && !rec_ovf;
    assign rec_fill_new = rec_fill_eff + lpc_pkg::FILL_W'(rec_store);
    assign rec_drop_new = rec_drop_eff || rec_ovf;
    assign rec_commit   = last && !rec_drop_new;

    assign out_free = !out_valid_reg || out_ready;
    assign asg_tag  = asg_q[lpc_pkg::ASG_W-1:1];

    always_comb
    begin
        sweep_next       = sweep_reg;
        gen_next         = gen_reg;
        rec_open_next    = rec_open_reg;
        rec_drop_next    = rec_drop_reg;
        rec_fill_next    = rec_fill_reg;
        ovf_flag_next    = ovf_flag_reg;
        out_valid_next   = out_valid_reg;
        rec_kind_next    = rec_kind_reg;
        rec_slot_next    = rec_slot_reg;
        mode_next        = mode_reg;
        scan_slot_next   = scan_slot_reg;
        cur_slot_next    = cur_slot_reg;
        dlen_next        = dlen_reg;
        dcnt_next        = dcnt_reg;
        chlen_next       = chlen_reg;
        chcnt_next       = chcnt_reg;
        ant_next         = ant_reg;
        alen_next        = alen_reg;
        acnt_next        = acnt_reg;
        open_next        = open_reg;
        pend_next        = pend_reg;
        cur_lit_next     = cur_lit_reg;
        verdict_next     = verdict_reg;
        out_verdict_next = out_verdict_reg;
        out_ovf_next     = out_ovf_reg;

        cpres_we = 1'b0;
        hpres_we = 1'b0;
        cpres_wd = 1'b0;
        hpres_wd = 1'b0;
        clen_we  = 1'b0;
        hlen_we  = 1'b0;
        tab_wa   = in_slot;
        clen_wd  = lpc_pkg::CLEN_W'(rec_fill_new);
        hlen_wd  = lpc_pkg::HLEN_W'(rec_fill_new);
        tab_ra   = cur_slot_reg;
        lits_we  = 1'b0;
        lits_wa  = lpc_pkg::lit_addr(in_slot, lpc_pkg::CLEN_W'(rec_fill_eff));
        lits_wd  = {lpc_pkg::var_of(literal_var), literal_negated};
        lits_ra  = lpc_pkg::lit_addr(cur_slot_reg, dcnt_reg);
        chids_we = 1'b0;
        chids_wa = lpc_pkg::chain_addr(in_slot, lpc_pkg::HLEN_W'(rec_fill_eff));
        chids_wd = lpc_pkg::slot_of(antecedent_id);
        chids_ra = lpc_pkg::chain_addr(cur_slot_reg, chcnt_reg);
        asg_we   = 1'b0;
        asg_wa   = lits_q[lpc_pkg::LIT_W-1:1];
        asg_wd   = {gen_reg, lits_q[0]};
        asg_ra   = lits_q[lpc_pkg::LIT_W-1:1];

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (cmd.op)
            lpc_pkg::S_INIT_CLR:
            begin
                tab_wa     = sweep_reg;
                cpres_we   = 1'b1;
                hpres_we   = 1'b1;
                asg_we     = 1'b1;
                asg_wa     = lpc_pkg::VAR_W'(sweep_reg);
                asg_wd     = '0;
                sweep_next = sweep_reg + 1'b1;
            end
            lpc_pkg::S_TAG_CLR:
            begin
                asg_we     = 1'b1;
                asg_wa     = lpc_pkg::VAR_W'(sweep_reg);
                asg_wd     = '0;
                sweep_next = sweep_reg + 1'b1;
            end
            lpc_pkg::S_IDLE:
            begin
                tab_ra = in_slot;
                if (rec_item)
                begin
                    // The first item of a record clears the slot; the last one
                    // sets it again unless the record was dropped.
                    cpres_we      = !rec_kind && (rec_new || last);
                    hpres_we      = rec_kind && (rec_new || last);
                    cpres_wd      = rec_commit;
                    hpres_wd      = rec_commit;
                    clen_we       = !rec_kind && rec_commit;
                    hlen_we       = rec_kind && rec_commit;
                    lits_we       = !rec_kind && rec_store;
                    chids_we      = rec_kind && rec_store;
                    ovf_flag_next = ovf_flag_reg || rec_ovf;
                    rec_kind_next = rec_kind;
                    rec_slot_next = in_slot;
                    rec_open_next = !last;
                    rec_fill_next = last ? '0 : rec_fill_new;
                    rec_drop_next = last ? 1'b0 : rec_drop_new;
                end
                else if (cmd.accept && id_valid && command == lpc_pkg::CMD_FORGET)
                begin
                    cpres_we = 1'b1;
                    hpres_we = 1'b1;
                end
                if (cmd.accept)
                begin
                    verdict_next   = 1'b0;
                    scan_slot_next = '0;
                    cur_slot_next  = in_slot;
                    if (command == lpc_pkg::CMD_CHECK_ALL)
                        mode_next = lpc_pkg::MODE_ALL;
                    else if (command == lpc_pkg::CMD_FINALIZE)
                        mode_next = lpc_pkg::MODE_FINAL;
                    else
                        mode_next = lpc_pkg::MODE_ONE;
                end
            end
            lpc_pkg::S_SCAN_RD:
            begin
                tab_ra        = scan_slot_reg;
                cur_slot_next = scan_slot_reg;
            end
            lpc_pkg::S_SCAN_EV:
            begin
                if (status.scan_abort)
                    verdict_next = 1'b0;
            end
            lpc_pkg::S_NEXT:
                scan_slot_next = scan_slot_reg + 1'b1;
            lpc_pkg::S_V_START:
            begin
                // On wrap the tag table is swept, so the new generation is one.
                gen_next   = (gen_reg == '1) ? lpc_pkg::GEN_W'(1) : gen_reg + 1'b1;
                sweep_next = '0;
            end
            lpc_pkg::S_V_LEN:
                tab_ra = cur_slot_reg;
            lpc_pkg::S_V_LEN2:
            begin
                dlen_next  = clen_q;
                chlen_next = hlen_q;
                dcnt_next  = '0;
                chcnt_next = '0;
            end
            lpc_pkg::S_D_RD:
                lits_ra = lpc_pkg::lit_addr(cur_slot_reg, dcnt_reg);
            lpc_pkg::S_D_WR:
            begin
                asg_we    = 1'b1;
                dcnt_next = dcnt_reg + 1'b1;
            end
            lpc_pkg::S_C_RD:
                chids_ra = lpc_pkg::chain_addr(cur_slot_reg, chcnt_reg);
            lpc_pkg::S_A_RD:
            begin
                tab_ra   = chids_q;
                ant_next = chids_q;
            end
            lpc_pkg::S_A_EV:
            begin
                alen_next = clen_q;
                acnt_next = '0;
                open_next = '0;
            end
            lpc_pkg::S_L_RD:
                lits_ra = lpc_pkg::lit_addr(ant_reg, acnt_reg);
            lpc_pkg::S_L_AS:
            begin
                asg_ra       = lits_q[lpc_pkg::LIT_W-1:1];
                cur_lit_next = lits_q;
            end
            lpc_pkg::S_L_EV:
            begin
                if (asg_tag != gen_reg)
                begin
                    open_next = (open_reg == 2'd2) ? 2'd2 : open_reg + 1'b1;
                    pend_next = cur_lit_reg;
                end
                acnt_next = acnt_reg + 1'b1;
            end
            lpc_pkg::S_A_END:
            begin
                // A unit antecedent forces its one open literal true.
                if (open_reg == 2'd1)
                begin
                    asg_we = 1'b1;
                    asg_wa = pend_reg[lpc_pkg::LIT_W-1:1];
                    asg_wd = {gen_reg, !pend_reg[0]};
                end
                chcnt_next = chcnt_reg + 1'b1;
            end
            lpc_pkg::S_V_OK:
                verdict_next = 1'b1;
            lpc_pkg::S_V_FAIL:
                verdict_next = 1'b0;
            lpc_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = verdict_reg;
                    out_ovf_next     = ovf_flag_reg;
                    ovf_flag_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            gen_reg       <= '0;
            rec_open_reg  <= 1'b0;
            rec_drop_reg  <= 1'b0;
            rec_fill_reg  <= '0;
            ovf_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            gen_reg       <= gen_next;
            rec_open_reg  <= rec_open_next;
            rec_drop_reg  <= rec_drop_next;
            rec_fill_reg  <= rec_fill_next;
            ovf_flag_reg  <= ovf_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_kind_reg    <= rec_kind_next;
        rec_slot_reg    <= rec_slot_next;
        mode_reg        <= mode_next;
        scan_slot_reg   <= scan_slot_next;
        cur_slot_reg    <= cur_slot_next;
        dlen_reg        <= dlen_next;
        dcnt_reg        <= dcnt_next;
        chlen_reg       <= chlen_next;
        chcnt_reg       <= chcnt_next;
        ant_reg         <= ant_next;
        alen_reg        <= alen_next;
        acnt_reg        <= acnt_next;
        open_reg        <= open_next;
        pend_reg        <= pend_next;
        cur_lit_reg     <= cur_lit_next;
        verdict_reg     <= verdict_next;
        out_verdict_reg <= out_verdict_next;
        out_ovf_reg     <= out_ovf_next;
    end

    lpc_ram #(.WIDTH(1), .DEPTH(lpc_pkg::CLAUSE_SLOTS)) u_cpres (
        .clk(clk), .we(cpres_we), .waddr(tab_wa), .wdata(cpres_wd),
        .raddr(tab_ra), .rdata(cpres_q)
    );

    lpc_ram #(.WIDTH(1), .DEPTH(lpc_pkg::CLAUSE_SLOTS)) u_hpres (
        .clk(clk), .we(hpres_we), .waddr(tab_wa), .wdata(hpres_wd),
        .raddr(tab_ra), .rdata(hpres_q)
    );

    lpc_ram #(.WIDTH(lpc_pkg::CLEN_W), .DEPTH(lpc_pkg::CLAUSE_SLOTS)) u_clen (
        .clk(clk), .we(clen_we), .waddr(tab_wa), .wdata(clen_wd),
        .raddr(tab_ra), .rdata(clen_q)
    );

    lpc_ram #(.WIDTH(lpc_pkg::HLEN_W), .DEPTH(lpc_pkg::CLAUSE_SLOTS)) u_hlen (
        .clk(clk), .we(hlen_we), .waddr(tab_wa), .wdata(hlen_wd),
        .raddr(tab_ra), .rdata(hlen_q)
    );

    lpc_ram #(.WIDTH(lpc_pkg::LIT_W),
              .DEPTH(lpc_pkg::CLAUSE_SLOTS * lpc_pkg::MAX_LITERALS)) u_lits (
        .clk(clk), .we(lits_we), .waddr(lits_wa), .wdata(lits_wd),
        .raddr(lits_ra), .rdata(lits_q)
    );

    lpc_ram #(.WIDTH(lpc_pkg::SLOT_W),
              .DEPTH(lpc_pkg::CLAUSE_SLOTS * lpc_pkg::MAX_CHAIN)) u_chids (
        .clk(clk), .we(chids_we), .waddr(chids_wa), .wdata(chids_wd),
        .raddr(chids_ra), .rdata(chids_q)
    );

    lpc_ram #(.WIDTH(lpc_pkg::ASG_W), .DEPTH(lpc_pkg::VAR_COUNT)) u_asg (
        .clk(clk), .we(asg_we), .waddr(asg_wa), .wdata(asg_wd),
        .raddr(asg_ra), .rdata(asg_q)
    );

    always_comb
    begin
        status.sweep_last  = (sweep_reg == lpc_pkg::SLOT_W'(lpc_pkg::CLAUSE_SLOTS - 1));
        status.pres_ok     = cpres_q && hpres_q;
        status.scan_verify = cpres_q && hpres_q &&
                             ((mode_reg == lpc_pkg::MODE_ALL) || (clen_q == '0));
        status.scan_abort  = (mode_reg == lpc_pkg::MODE_ALL) && hpres_q && !cpres_q;
        status.gen_wrap    = (gen_reg == '1);
        status.dlen_zero   = (clen_q == '0);
        status.d_last      = ((dcnt_reg + lpc_pkg::CLEN_W'(1)) == dlen_reg);
        status.ch_end      = (chcnt_reg == chlen_reg);
        status.ant_absent  = !cpres_q;
        status.lit_end     = (acnt_reg == alen_reg);
        status.lit_sat     = (asg_tag == gen_reg) && (asg_q[0] != cur_lit_reg[0]);
        status.open_zero   = (open_reg == 2'd0);
        status.open_multi  = (open_reg == 2'd2);
        status.slot_last   = (scan_slot_reg == lpc_pkg::SLOT_W'(lpc_pkg::CLAUSE_SLOTS - 1));
        status.out_free    = out_free;
        status.mode        = mode_reg;
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = out_verdict_reg;
    assign overflow_seen = out_ovf_reg;

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == lpc_pkg::S_FINISH))
        else $error("result loaded outside the finish step");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_fill_reg <= lpc_pkg::FILL_W'(lpc_pkg::FILL_MAX))
        else $error("record fill beyond its bound");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lpc_pkg::S_V_START) |=> (gen_reg != '0))
        else $error("check generation zero during a walk");

    a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lpc_pkg::S_FINISH && out_free) |=> !ovf_flag_reg)
        else $error("overflow flag not cleared by a query result");

endmodule

`default_nettype wire

>>> hdl/lrat_proof_chain_checker.sv
// ============================================================================
// lrat_proof_chain_checker: LRAT reverse unit propagation checker
// Clause and antecedent chain tables with validate, check-all and finalize.
// ============================================================================
// After reset the block sweeps its presence and assignment tables, one entry
// a cycle, with in_ready low. Record and forget items are then taken in the
// idle state without lowering in_ready. Queries hold in_ready low while they
// walk the tables: a verification assigns the literals of the derived clause
// and then, per antecedent of its chain, reads the antecedent's literals;
// a tag sweep is added whenever the check generation wraps.
// Check-all and finalize visit the slots in turn and run the verifications
// they start. Each query gives one result.
`timescale 1ns / 1ps
`default_nettype none

module lrat_proof_chain_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [lpc_pkg::CMD_W-1:0] command,
    input  wire logic [lpc_pkg::ID_W-1:0]  clause_id,
    input  wire logic                      id_valid,
    input  wire logic                      has_element,
    input  wire logic [lpc_pkg::ID_W-1:0]  literal_var,
    input  wire logic                      literal_negated,
    input  wire logic [lpc_pkg::ID_W-1:0]  antecedent_id,
    input  wire logic                      last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           verdict,
    output logic                           overflow_seen
);

    lpc_pkg::dp_cmd_t    cmd;
    lpc_pkg::dp_status_t status;

    lpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .id_valid(id_valid), .status(status), .cmd(cmd)
    );

    lpc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .command(command), .clause_id(clause_id), .id_valid(id_valid),
        .has_element(has_element), .literal_var(literal_var),
        .literal_negated(literal_negated), .antecedent_id(antecedent_id),
        .last(last), .out_valid(out_valid), .out_ready(out_ready),
        .verdict(verdict), .overflow_seen(overflow_seen)
    );

endmodule

`default_nettype wire
